>>> hdl/rbsi_pkg.sv
package rbsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int EPS_W         = 16;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd2;

    localparam logic signed [WORD_W-1:0] BOX_MIN_RST = -32'sd65536;
    localparam logic signed [WORD_W-1:0] BOX_MAX_RST = 32'sd65536;
    localparam logic [EPS_W-1:0]         EPSILON_RST = 16'd1;

    localparam logic signed [WORD_W-1:0] SAT_POS = 32'sh7FFFFFFF;
    localparam logic signed [WORD_W-1:0] SAT_NEG = 32'sh80000000;

    typedef struct packed {
        logic signed [WORD_W-1:0] origin_x;
        logic signed [WORD_W-1:0] origin_y;
        logic signed [WORD_W-1:0] origin_z;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                     hit;
        logic signed [WORD_W-1:0] t_enter;
        logic signed [WORD_W-1:0] t_exit;
    } result_t;

    // Side information that travels down the divider pipeline.
    typedef struct packed {
        logic par;
        logic neg;
        logic num_pos;
        logic num_neg;
    } div_ctl_t;

endpackage

>>> hdl/rbsi_div.sv
// Pipelined saturating fixed-point divider: one quotient bit per stage.
// Result is (num << FRAC_BITS) / den, truncated toward zero, clamped to 32 bits.
module rbsi_div #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              adv,
    input  logic signed [rbsi_pkg::WORD_W:0]  num,
    input  logic signed [rbsi_pkg::WORD_W-1:0] den,
    input  logic [rbsi_pkg::EPS_W-1:0]        eps,
    output logic signed [rbsi_pkg::WORD_W-1:0] quo
);
    import rbsi_pkg::*;

    // Quotient below 2^QW covers every value that does not saturate.
    localparam int QW = WORD_W + 1;
    localparam int NW = WORD_W + 1 + FRAC_BITS;   // scaled numerator magnitude
    localparam int RW = WORD_W + 1;               // partial remainder

    logic [NW-1:0]     nm;
    logic [WORD_W-1:0] dm;
    logic [WORD_W:0]   num_mag;
    div_ctl_t          ctl_in;

    logic [NW-1:0]     n_reg   [0:QW];
    logic [RW-1:0]     r_reg   [0:QW];
    logic [QW-1:0]     q_reg   [0:QW];
    logic [WORD_W-1:0] d_reg   [0:QW];
    div_ctl_t          c_reg   [0:QW];
    logic              ovf_reg [0:QW];

    always_comb
    begin
        num_mag = num[WORD_W] ? (WORD_W+1)'(-num) : num;
        dm      = den[WORD_W-1] ? WORD_W'(-den) : den;
        nm      = {num_mag, {FRAC_BITS{1'b0}}};
        ctl_in.par     = (dm == '0) || (dm < WORD_W'(eps));
        ctl_in.neg     = num[WORD_W] ^ den[WORD_W-1];
        ctl_in.num_pos = !num[WORD_W] && (num != '0);
        ctl_in.num_neg = num[WORD_W];
    end

    // Stage 0: quotient bits above QW mean overflow; that is (nm >> QW) >= dm.
    // Without overflow the upper numerator bits are smaller than dm and form
    // the starting remainder.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]   <= nm;
            r_reg[0]   <= RW'(nm >> QW);
            q_reg[0]   <= '0;
            d_reg[0]   <= dm;
            c_reg[0]   <= ctl_in;
            ovf_reg[0] <= (NW > QW) && ((nm >> QW) >= NW'(dm));
        end
    end

    // The low QW numerator bits are shifted in, one per stage, MSB first.
    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [RW-1:0] trial;
        logic          take;
        always_comb
        begin
            trial = {r_reg[s][RW-2:0], n_reg[s][QW-1-s]};
            take  = trial >= RW'(d_reg[s]);
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_reg[s+1]   <= n_reg[s];
                r_reg[s+1]   <= take ? trial - RW'(d_reg[s]) : trial;
                q_reg[s+1]   <= {q_reg[s][QW-2:0], take};
                d_reg[s+1]   <= d_reg[s];
                c_reg[s+1]   <= c_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    div_ctl_t   cf;
    logic [QW-1:0] qf;
    always_comb
    begin
        cf = c_reg[QW];
        qf = q_reg[QW];
        if (cf.par)
            quo = cf.num_pos ? SAT_POS : (cf.num_neg ? SAT_NEG : '0);
        else if (cf.neg)
            quo = (ovf_reg[QW] || qf > QW'(33'h080000000)) ? SAT_NEG
                                                          : WORD_W'(-qf);
        else
            quo = (ovf_reg[QW] || qf > QW'(33'h07FFFFFFF)) ? SAT_POS
                                                          : WORD_W'(qf);
    end
endmodule

>>> hdl/ray_box_slab_intersect_core.sv
// Ray versus axis-aligned box intersection, slab method, fixed point.
// Input channel: in_valid / in_stall carry one ray beat (origin and direction,
// signed Q16.16). Output channel: out_valid / out_stall carry one result beat
// (hit, t_enter, t_exit); every ray gives exactly one result, in order.
// The configuration port (cfg_we, cfg_idx, cfg_data) sets box_min, box_max and
// epsilon; write it only while no ray is in flight.
// From input beat to output beat the pipeline is one numerator stage,
// 34 divider stages (an entry stage plus 33 quotient stages, one divider per
// slab plane) and three stages that order the pairs and combine them.
// Throughput is one ray per cycle. The pipeline advances as a whole: when the
// receiver stalls and the last stage holds a result, every stage holds, so
// in_stall follows out_stall while the output is occupied. Empty pipeline
// slots do not hold anything back.
// Reset clears all valid bits and restores the register defaults; payload
// registers are not reset.
module ray_box_slab_intersect_core #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [rbsi_pkg::WORD_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rbsi_pkg::ray_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output rbsi_pkg::result_t                   out_data
);
    import rbsi_pkg::*;

    localparam int DIV_LAT = WORD_W + 2;   // stage 0 plus 33 quotient stages
    localparam int LAT     = 1 + DIV_LAT + 3;

    logic signed [WORD_W-1:0] box_min_reg, box_max_reg;
    logic [EPS_W-1:0]         eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= BOX_MIN_RST;
            box_max_reg <= BOX_MAX_RST;
            eps_reg     <= EPSILON_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_BOX_MIN: box_min_reg <= cfg_data;
                CFG_BOX_MAX: box_max_reg <= cfg_data;
                CFG_EPSILON: eps_reg     <= cfg_data[EPS_W-1:0];
                default:     ;
            endcase
        end
    end

    // One global enable: everything moves unless a finished result is blocked.
    logic adv;
    logic [LAT-1:0] v_reg;
    assign adv      = !(v_reg[LAT-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[LAT-2:0], in_valid};
    end

    // Stage 1: the six numerators, 33 bits each.
    logic signed [WORD_W:0]   nlo_reg [3];
    logic signed [WORD_W:0]   nhi_reg [3];
    logic signed [WORD_W-1:0] dir_reg [3];
    logic signed [WORD_W-1:0] org [3], dir [3];
    always_comb
    begin
        org[0] = in_data.origin_x; org[1] = in_data.origin_y; org[2] = in_data.origin_z;
        dir[0] = in_data.dir_x;    dir[1] = in_data.dir_y;    dir[2] = in_data.dir_z;
    end

    logic signed [WORD_W-1:0] qa [3], qb [3];
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nlo_reg[a] <= (WORD_W+1)'(box_min_reg) - (WORD_W+1)'(org[a]);
                nhi_reg[a] <= (WORD_W+1)'(box_max_reg) - (WORD_W+1)'(org[a]);
                dir_reg[a] <= dir[a];
            end
        end
        rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_a (
            .clk(clk), .adv(adv), .num(nlo_reg[a]),
            .den(dir_reg[a]), .eps(eps_reg), .quo(qa[a]));
        rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_b (
            .clk(clk), .adv(adv), .num(nhi_reg[a]),
            .den(dir_reg[a]), .eps(eps_reg), .quo(qb[a]));
    end

    // Order each pair.
    logic signed [WORD_W-1:0] lo_reg [3], hi_reg [3];
    for (genvar a = 0; a < 3; a++)
    begin : g_ord
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lo_reg[a] <= (qa[a] > qb[a]) ? qb[a] : qa[a];
                hi_reg[a] <= (qa[a] > qb[a]) ? qa[a] : qb[a];
            end
        end
    end

    // Max of entries, min of exits, in two steps.
    logic signed [WORD_W-1:0] tin01_reg, tout01_reg, lo2_reg, hi2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tin01_reg  <= (lo_reg[1] > lo_reg[0]) ? lo_reg[1] : lo_reg[0];
            tout01_reg <= (hi_reg[1] < hi_reg[0]) ? hi_reg[1] : hi_reg[0];
            lo2_reg    <= lo_reg[2];
            hi2_reg    <= hi_reg[2];
        end
    end

    logic signed [WORD_W-1:0] tin, tout;
    result_t res_reg;
    always_comb
    begin
        tin  = (lo2_reg > tin01_reg)  ? lo2_reg : tin01_reg;
        tout = (hi2_reg < tout01_reg) ? hi2_reg : tout01_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.hit     <= (tin <= tout);
            res_reg.t_enter <= (tin <= tout) ? tin  : '0;
            res_reg.t_exit  <= (tin <= tout) ? tout : '0;
        end
    end

    assign out_valid = v_reg[LAT-1];
    assign out_data  = res_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("held result changed");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.hit) |-> (out_data.t_enter == '0 && out_data.t_exit == '0))
        else $error("miss with nonzero distances");
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.hit) |-> (out_data.t_enter <= out_data.t_exit))
        else $error("hit with entry beyond exit");
endmodule
